### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define YRR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yrr port check failed");

// Check that cons holds in the cycle after ante.
`define YRR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yrr port check failed");

`endif

### hw/rtl/yrr_pkg.sv
// ---------------------------------------------------------------------------
// yrr_pkg
// Shared widths, codes and the command type passed from the front end
// through the command queue to the memory back end.
// ---------------------------------------------------------------------------
package yrr_pkg;

    // Default frame limits for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Largest even dimension a 9-bit register can express
    localparam int DIM_CAP = 510;

    localparam int LUMA_PIXEL_STRIDE = 1;

    localparam int CFG_DATA_W    = 9;
    localparam int CFG_INDEX_W   = 3;
    localparam int LUMA_ADDR_W   = 16;
    localparam int CHROMA_ADDR_W = 15;
    localparam int LUMA_DEPTH    = 1 << LUMA_ADDR_W;
    localparam int CHROMA_DEPTH  = 1 << CHROMA_ADDR_W;
    localparam int INDEX_W       = 17;
    localparam int BYTE_W        = 8;

    // Command queue depth, a power of two
    localparam int QUEUE_DEPTH = 4;

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Plane codes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_PITCH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_PITCH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_STRIDE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_FORMAT    = 3'd6;

    // Rotation and format codes
    localparam logic [1:0] ROT_NONE  = 2'd0;
    localparam logic [1:0] ROT_CW90  = 2'd1;
    localparam logic [1:0] ROT_CW270 = 2'd2;
    localparam logic       FMT_NV21  = 1'b0;
    localparam logic       FMT_I420  = 1'b1;

    // Walk phases
    localparam logic [1:0] PH_LUMA     = 2'd0;
    localparam logic [1:0] PH_CHROMA_A = 2'd1;
    localparam logic [1:0] PH_CHROMA_B = 2'd2;

    // Command: a store write (load) or a store read (fetch)
    typedef struct packed {
        logic                     is_fetch;
        logic [1:0]               plane;
        logic [LUMA_ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]        wdata;
        logic [INDEX_W-1:0]       index;
        logic                     last;
    } yrr_cmd_t;

endpackage

### hw/rtl/yrr_cmd_queue.sv
// ---------------------------------------------------------------------------
// yrr_cmd_queue
// Small FIFO of commands between the front end and the memory back end.
// ---------------------------------------------------------------------------
module yrr_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  yrr_pkg::yrr_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output yrr_pkg::yrr_cmd_t head_cmd
);

    localparam int PTR_W = $clog2(yrr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(yrr_pkg::QUEUE_DEPTH + 1);

    yrr_pkg::yrr_cmd_t entry_reg [yrr_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(yrr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/yrr_front.sv
// ---------------------------------------------------------------------------
// yrr_front
// Accepts input transactions and holds the configuration registers and the
// destination walk. Loads become store writes; fetches become store reads
// at the address of the current destination byte.
// ---------------------------------------------------------------------------
module yrr_front #(
    parameter int MAX_WIDTH  = yrr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = yrr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [1:0]                          plane_sel,
    input  logic [yrr_pkg::LUMA_ADDR_W-1:0]     src_offset,
    input  logic [yrr_pkg::BYTE_W-1:0]          src_byte,
    input  logic                                cfg_we,
    input  logic [yrr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [yrr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                push,
    output yrr_pkg::yrr_cmd_t                   push_cmd,
    input  logic                                queue_full
);

    localparam int MAX_DIM_RAW = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int MAX_DIM     = (MAX_DIM_RAW > yrr_pkg::DIM_CAP) ? yrr_pkg::DIM_CAP
                                                                  : MAX_DIM_RAW;
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = CNT_W + 1;
    localparam int PROD_W = CNT_W + yrr_pkg::CFG_DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int DW     = yrr_pkg::CFG_DATA_W;

    // Clamp a dimension to [2, hi] and force it even
    function automatic logic [DIM_W-1:0] fit_even(input logic [DW-1:0] v, input int hi);
        int t;
        t = int'(v);
        if (t < 2)
        begin
            t = 2;
        end
        if (t > hi)
        begin
            t = hi;
        end
        t = t & ~1;
        return DIM_W'(t);
    endfunction

    // Configuration registers
    logic [DW-1:0] frame_width_reg,   frame_width_next;
    logic [DW-1:0] frame_height_reg,  frame_height_next;
    logic [DW-1:0] luma_pitch_reg,    luma_pitch_next;
    logic [DW-1:0] chroma_pitch_reg,  chroma_pitch_next;
    logic [1:0]    chroma_stride_reg, chroma_stride_next;
    logic [1:0]    rotation_reg,      rotation_next;
    logic          out_format_reg,    out_format_next;

    // Walk state
    logic [yrr_pkg::INDEX_W-1:0] out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]            row_reg, row_next;
    logic [CNT_W-1:0]            col_reg, col_next;
    logic [1:0]                  phase_reg, phase_next;
    logic                        half_reg, half_next;

    logic                    cfg_restart;
    logic                    accept;
    logic                    fetch_acc;
    logic                    plane_ok;
    logic [DIM_W-1:0]        w, h;
    logic [CNT_W-1:0]        cw, ch;
    logic [1:0]              rot;
    logic                    is_chroma;
    logic [DIM_W-1:0]        outer_lim, inner_lim;
    logic [CNT_W-1:0]        mul_a;
    logic [CNT_W-1:0]        add_term;
    logic [DW-1:0]           pitch;
    logic [PROD_W-1:0]       prod;
    logic [SUM_W-1:0]        term;
    logic [yrr_pkg::LUMA_ADDR_W-1:0] walk_addr;
    logic                    take_v;
    logic [1:0]              walk_plane;
    logic                    at_end;
    logic                    last;
    logic [DIM_W-1:0]        col_inc, row_inc;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign fetch_acc = accept && (req_type == yrr_pkg::REQ_FETCH);
    assign plane_ok  = (plane_sel == yrr_pkg::PLANE_Y) || (plane_sel == yrr_pkg::PLANE_U)
                    || (plane_sel == yrr_pkg::PLANE_V);
    // Drop loads aimed at no plane
    assign push      = accept && ((req_type == yrr_pkg::REQ_FETCH) || plane_ok);

    // Decode configuration writes
    always_comb
    begin
        frame_width_next   = frame_width_reg;
        frame_height_next  = frame_height_reg;
        luma_pitch_next    = luma_pitch_reg;
        chroma_pitch_next  = chroma_pitch_reg;
        chroma_stride_next = chroma_stride_reg;
        rotation_next      = rotation_reg;
        out_format_next    = out_format_reg;
        cfg_restart        = 1'b0;
        if (cfg_we)
        begin
            cfg_restart = 1'b1;
            case (cfg_index)
                yrr_pkg::CFG_FRAME_WIDTH:   frame_width_next   = cfg_wdata;
                yrr_pkg::CFG_FRAME_HEIGHT:  frame_height_next  = cfg_wdata;
                yrr_pkg::CFG_LUMA_PITCH:    luma_pitch_next    = cfg_wdata;
                yrr_pkg::CFG_CHROMA_PITCH:  chroma_pitch_next  = cfg_wdata;
                yrr_pkg::CFG_CHROMA_STRIDE: chroma_stride_next = cfg_wdata[1:0];
                yrr_pkg::CFG_ROTATION:      rotation_next      = cfg_wdata[1:0];
                yrr_pkg::CFG_OUT_FORMAT:    out_format_next    = cfg_wdata[0];
                default:                    cfg_restart        = 1'b0;
            endcase
        end
    end

    // Frame geometry
    assign w   = fit_even(frame_width_reg, MAX_WIDTH);
    assign h   = fit_even(frame_height_reg, MAX_HEIGHT);
    assign cw  = CNT_W'(w >> 1);
    assign ch  = CNT_W'(h >> 1);
    assign rot = ((rotation_reg == yrr_pkg::ROT_CW90) || (rotation_reg == yrr_pkg::ROT_CW270))
               ? rotation_reg : yrr_pkg::ROT_NONE;
    assign is_chroma = (phase_reg != yrr_pkg::PH_LUMA);

    // Pick limits and address operands for the current phase and rotation
    always_comb
    begin
        pitch = is_chroma ? chroma_pitch_reg : luma_pitch_reg;
        case (rot)
            yrr_pkg::ROT_CW90:
            begin
                if (is_chroma)
                begin
                    outer_lim = DIM_W'(cw);
                    inner_lim = DIM_W'(ch);
                    mul_a     = CNT_W'(DIM_W'(ch) - DIM_W'(1) - DIM_W'(col_reg));
                end
                else
                begin
                    outer_lim = w;
                    inner_lim = h;
                    mul_a     = CNT_W'(h - DIM_W'(1) - DIM_W'(col_reg));
                end
                add_term = row_reg;
            end
            yrr_pkg::ROT_CW270:
            begin
                if (is_chroma)
                begin
                    outer_lim = DIM_W'(cw);
                    inner_lim = DIM_W'(ch);
                    add_term  = CNT_W'(DIM_W'(cw) - DIM_W'(1) - DIM_W'(row_reg));
                end
                else
                begin
                    outer_lim = w;
                    inner_lim = h;
                    add_term  = CNT_W'(w - DIM_W'(1) - DIM_W'(row_reg));
                end
                mul_a = col_reg;
            end
            default:
            begin
                if (is_chroma)
                begin
                    outer_lim = DIM_W'(ch);
                    inner_lim = DIM_W'(cw);
                end
                else
                begin
                    outer_lim = h;
                    inner_lim = w;
                end
                mul_a    = row_reg;
                add_term = col_reg;
            end
        endcase
    end

    // Row term through the shared multiplier, pixel term scaled by its stride
    assign prod = PROD_W'(mul_a) * PROD_W'(pitch);
    assign term = is_chroma ? SUM_W'(add_term) * SUM_W'(chroma_stride_reg)
                            : SUM_W'(add_term) * SUM_W'(yrr_pkg::LUMA_PIXEL_STRIDE);
    assign walk_addr = yrr_pkg::LUMA_ADDR_W'(SUM_W'(prod) + term);

    // Chroma plane choice and end of frame
    assign take_v     = (out_format_reg == yrr_pkg::FMT_NV21) ? !half_reg
                                                              : (phase_reg == yrr_pkg::PH_CHROMA_B);
    assign walk_plane = !is_chroma ? yrr_pkg::PLANE_Y
                      : (take_v ? yrr_pkg::PLANE_V : yrr_pkg::PLANE_U);
    assign at_end     = (DIM_W'(col_reg) == inner_lim - DIM_W'(1))
                     && (DIM_W'(row_reg) == outer_lim - DIM_W'(1));
    assign last       = at_end
                     && (((out_format_reg == yrr_pkg::FMT_NV21)
                          && (phase_reg == yrr_pkg::PH_CHROMA_A) && half_reg)
                      || ((out_format_reg == yrr_pkg::FMT_I420)
                          && (phase_reg == yrr_pkg::PH_CHROMA_B)));

    // Build the command
    always_comb
    begin
        push_cmd.is_fetch = (req_type == yrr_pkg::REQ_FETCH);
        push_cmd.plane    = (req_type == yrr_pkg::REQ_FETCH) ? walk_plane : plane_sel;
        push_cmd.addr     = (req_type == yrr_pkg::REQ_FETCH) ? walk_addr : src_offset;
        push_cmd.wdata    = src_byte;
        push_cmd.index    = out_pos_reg;
        push_cmd.last     = last;
    end

    // Advance the walk on each fetch
    assign col_inc = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc = DIM_W'(row_reg) + DIM_W'(1);

    always_comb
    begin
        out_pos_next = out_pos_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        phase_next   = phase_reg;
        half_next    = half_reg;
        if (cfg_restart || (fetch_acc && last))
        begin
            out_pos_next = '0;
            row_next     = '0;
            col_next     = '0;
            phase_next   = yrr_pkg::PH_LUMA;
            half_next    = 1'b0;
        end
        else if (fetch_acc)
        begin
            out_pos_next = out_pos_reg + 1'b1;
            if (is_chroma && (out_format_reg == yrr_pkg::FMT_NV21) && !half_reg)
            begin
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                if (col_inc >= inner_lim)
                begin
                    col_next = '0;
                    if (row_inc >= outer_lim)
                    begin
                        row_next   = '0;
                        phase_next = (phase_reg == yrr_pkg::PH_LUMA) ? yrr_pkg::PH_CHROMA_A
                                   : ((phase_reg == yrr_pkg::PH_CHROMA_A) ? yrr_pkg::PH_CHROMA_B
                                                                         : yrr_pkg::PH_LUMA);
                    end
                    else
                    begin
                        row_next = CNT_W'(row_inc);
                    end
                end
                else
                begin
                    col_next = CNT_W'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= DW'(256);
            frame_height_reg  <= DW'(256);
            luma_pitch_reg    <= DW'(256);
            chroma_pitch_reg  <= DW'(256);
            chroma_stride_reg <= 2'd2;
            rotation_reg      <= yrr_pkg::ROT_NONE;
            out_format_reg    <= yrr_pkg::FMT_NV21;
            out_pos_reg       <= '0;
            row_reg           <= '0;
            col_reg           <= '0;
            phase_reg         <= yrr_pkg::PH_LUMA;
            half_reg          <= 1'b0;
        end
        else
        begin
            frame_width_reg   <= frame_width_next;
            frame_height_reg  <= frame_height_next;
            luma_pitch_reg    <= luma_pitch_next;
            chroma_pitch_reg  <= chroma_pitch_next;
            chroma_stride_reg <= chroma_stride_next;
            rotation_reg      <= rotation_next;
            out_format_reg    <= out_format_next;
            out_pos_reg       <= out_pos_next;
            row_reg           <= row_next;
            col_reg           <= col_next;
            phase_reg         <= phase_next;
            half_reg          <= half_next;
        end
    end

endmodule

### hw/rtl/yrr_back.sv
// ---------------------------------------------------------------------------
// yrr_back
// Executes queued commands against the Y, U and V stores: loads write,
// fetches read into a registered stage and then into the output register.
// ---------------------------------------------------------------------------
module yrr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  yrr_pkg::yrr_cmd_t               cmd,
    output logic                            cmd_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [yrr_pkg::BYTE_W-1:0]      out_byte,
    output logic [yrr_pkg::INDEX_W-1:0]     out_index,
    output logic                            last_of_frame
);

    localparam int BW = yrr_pkg::BYTE_W;

    logic [BW-1:0] luma_mem [yrr_pkg::LUMA_DEPTH];
    logic [BW-1:0] u_mem    [yrr_pkg::CHROMA_DEPTH];
    logic [BW-1:0] v_mem    [yrr_pkg::CHROMA_DEPTH];

    logic [BW-1:0] luma_rd_reg, u_rd_reg, v_rd_reg;

    // Read stage
    logic                        s1_valid_reg, s1_valid_next;
    logic [1:0]                  s1_plane_reg;
    logic [yrr_pkg::INDEX_W-1:0] s1_index_reg;
    logic                        s1_last_reg;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [BW-1:0]               out_byte_reg;
    logic [yrr_pkg::INDEX_W-1:0] out_index_reg;
    logic                        out_last_reg;

    logic                                 out_free, s1_move, s1_free;
    logic                                 wr_en, rd_en;
    logic [yrr_pkg::CHROMA_ADDR_W-1:0]    chroma_addr;
    logic [BW-1:0]                        s1_sample;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || s1_move;
    // Loads always drain; fetches wait for a free read stage
    assign cmd_pop  = cmd_valid && (!cmd.is_fetch || s1_free);
    assign wr_en    = cmd_pop && !cmd.is_fetch;
    assign rd_en    = cmd_pop && cmd.is_fetch;
    assign chroma_addr = cmd.addr[yrr_pkg::CHROMA_ADDR_W-1:0];

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en && (cmd.plane == yrr_pkg::PLANE_Y))
        begin
            luma_mem[cmd.addr] <= cmd.wdata;
        end
        if (rd_en && (cmd.plane == yrr_pkg::PLANE_Y))
        begin
            luma_rd_reg <= luma_mem[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (cmd.plane == yrr_pkg::PLANE_U))
        begin
            u_mem[chroma_addr] <= cmd.wdata;
        end
        if (rd_en && (cmd.plane == yrr_pkg::PLANE_U))
        begin
            u_rd_reg <= u_mem[chroma_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (cmd.plane == yrr_pkg::PLANE_V))
        begin
            v_mem[chroma_addr] <= cmd.wdata;
        end
        if (rd_en && (cmd.plane == yrr_pkg::PLANE_V))
        begin
            v_rd_reg <= v_mem[chroma_addr];
        end
    end

    // Select the sample of the read stage
    always_comb
    begin
        case (s1_plane_reg)
            yrr_pkg::PLANE_U: s1_sample = u_rd_reg;
            yrr_pkg::PLANE_V: s1_sample = v_rd_reg;
            default:          s1_sample = luma_rd_reg;
        endcase
    end

    // Stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of both stages
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_plane_reg <= cmd.plane;
            s1_index_reg <= cmd.index;
            s1_last_reg  <= cmd.last;
        end
        if (s1_move)
        begin
            out_byte_reg  <= s1_sample;
            out_index_reg <= s1_index_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_index     = out_index_reg;
    assign last_of_frame = out_last_reg;

endmodule

### hw/rtl/yuv420_rotate_repack_top.sv
// ---------------------------------------------------------------------------
// yuv420_rotate_repack_top
// Planar YUV 4:2:0 frame store that reads back as NV21 or I420, rotated.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a load transaction writes src_byte at
// src_offset of the plane given by plane_sel; a fetch transaction returns
// the next byte of the destination frame on the output channel
// (out_valid/out_ready) with its out_index and a last_of_frame flag. Loads
// return nothing. After the last byte the walk starts again at byte 0.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle; a write to a known register restarts the walk.
// Throughput is one transaction per cycle while in_ready is high. A fetch
// is written into the command queue, read from the store into the read
// stage and then loaded into the output register, where out_valid rises;
// these are the three register stages of the path.
// When the receiver stalls, the output register and the read stage hold and
// the four-entry command queue fills; in_ready drops when it is full.
// Loads at the queue head keep draining while a fetch result waits.
// Reset clears the walk, the queue and the valid flags and restores the
// register defaults; store contents are undefined until written.
// ---------------------------------------------------------------------------
module yuv420_rotate_repack_top #(
    parameter int MAX_WIDTH  = yrr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = yrr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [1:0]                          plane_sel,
    input  logic [yrr_pkg::LUMA_ADDR_W-1:0]     src_offset,
    input  logic [yrr_pkg::BYTE_W-1:0]          src_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [yrr_pkg::BYTE_W-1:0]          out_byte,
    output logic [yrr_pkg::INDEX_W-1:0]         out_index,
    output logic                                last_of_frame,
    input  logic                                cfg_we,
    input  logic [yrr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [yrr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic              push;
    yrr_pkg::yrr_cmd_t push_cmd;
    logic              queue_full;
    logic              queue_not_empty;
    yrr_pkg::yrr_cmd_t head_cmd;
    logic              cmd_pop;

    // Accept and classify transactions
    yrr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .plane_sel  (plane_sel),
        .src_offset (src_offset),
        .src_byte   (src_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // Decouple front and back
    yrr_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    // Execute against the stores
    yrr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_index     (out_index),
        .last_of_frame (last_of_frame)
    );

endmodule

### hw/rtl/yrr_checker.sv
// ---------------------------------------------------------------------------
// yrr_checker
// Port-level checks of the repacker, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module yrr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             req_type,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [yrr_pkg::BYTE_W-1:0]       out_byte,
    input logic [yrr_pkg::INDEX_W-1:0]      out_index,
    input logic                             last_of_frame
);

    // Queue plus read stage plus output register
    localparam int CAP    = yrr_pkg::QUEUE_DEPTH + 2;
    localparam int PEND_W = $clog2(CAP + 2);

    logic              fetch_acc, out_acc;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              expect_zero_reg, expect_zero_next;

    assign fetch_acc = in_valid && in_ready && (req_type == yrr_pkg::REQ_FETCH);
    assign out_acc   = out_valid && out_ready;

    // Track fetches still owed a result, and a pending frame wrap
    always_comb
    begin
        pend_next = pend_reg;
        if (fetch_acc && !out_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_acc && !fetch_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
        expect_zero_next = expect_zero_reg;
        if (out_acc)
        begin
            expect_zero_next = last_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg        <= '0;
            expect_zero_reg <= 1'b0;
        end
        else
        begin
            pend_reg        <= pend_next;
            expect_zero_reg <= expect_zero_next;
        end
    end

    // A stalled result holds
    `YRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(out_index) && $stable(last_of_frame))

    // No result without an accepted fetch behind it
    `YRR_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, pend_reg != '0)

    // Outstanding fetches never exceed the buffering
    `YRR_ASSERT_IMPL(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= PEND_W'(CAP))

    // The byte after the end of a frame is byte zero
    `YRR_ASSERT_IMPL(a_wrap_zero, clk, rst_n, out_valid && expect_zero_reg, out_index == '0)

endmodule

bind yuv420_rotate_repack_top yrr_checker u_checker (.*);
